[src/cfp_pkg.sv]
`default_nettype none

package cfp_pkg;

   // Framing bytes.
   localparam logic [7:0] HEADER_BYTE = 8'hAA;
   localparam logic [7:0] TAIL_BYTE   = 8'hFF;

   // Position in the nine-byte frame.
   typedef enum logic [3:0] {
      POS_IDLE  = 4'd0,
      POS_HDR2  = 4'd1,
      POS_XH    = 4'd2,
      POS_XL    = 4'd3,
      POS_YH    = 4'd4,
      POS_YL    = 4'd5,
      POS_CK    = 4'd6,
      POS_TAIL1 = 4'd7,
      POS_TAIL2 = 4'd8
   } pos_type;

   // One decoded coordinate pair.
   typedef struct packed {
      logic [15:0] coord_x;
      logic [15:0] coord_y;
   } coord_type;

endpackage

`default_nettype wire

[src/coordinate_frame_parser.sv]
`default_nettype none

// Channel   Direction  Ports                                  Handshake
// req       in         req_rx_byte                            req_valid / req_ready
// rsp       out        rsp_coord_x, rsp_coord_y               rsp_valid / rsp_ready
//
// One received byte is taken per cycle while req_ready is high; a completed,
// checksum-clean frame's result is buffered for rsp with its last tail byte.
// The throughput is one beat per cycle, bounded only by the two-entry output
// buffer: req_ready falls only while both entries hold undelivered results.
// Reset is synchronous and active high; it returns the frame tracker to idle
// and empties the output buffer. Stalls on rsp back up into req_ready.

module coordinate_frame_parser (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [15:0] rsp_coord_x,
   output logic [15:0] rsp_coord_y
);
   import cfp_pkg::*;

   logic      beat_accept;
   logic      result_valid;
   coord_type result;
   coord_type rsp_data;

   // A byte is consumed whenever the output buffer has room for a possible
   // result, so the tracker advances on every accepted beat.
   assign beat_accept = req_valid && req_ready;

   // The tracker holds the frame position and the captured payload bytes,
   // and decides within the cycle of the second tail byte whether a result
   // goes out.
   cfp_tracker u_tracker (
      .clock          (clock),
      .reset          (reset),
      .beat_valid_i   (beat_accept),
      .beat_byte_i    (req_rx_byte),
      .result_valid_o (result_valid),
      .result_o       (result)
   );

   // The output register plus a skid entry decouple the two sides, so one
   // waiting result never stops new bytes from being taken; a second one does.
   cfp_out_buf u_out_buf (
      .clock       (clock),
      .reset       (reset),
      .push_i      (result_valid),
      .push_data_i (result),
      .ready_o     (req_ready),
      .valid_o     (rsp_valid),
      .ready_i     (rsp_ready),
      .data_o      (rsp_data)
   );

   assign rsp_coord_x = rsp_data.coord_x;
   assign rsp_coord_y = rsp_data.coord_y;

endmodule

`default_nettype wire

[src/cfp_tracker.sv]
`default_nettype none

module cfp_tracker (
   input  logic                clock,
   input  logic                reset,
   input  logic                beat_valid_i,
   input  logic [7:0]          beat_byte_i,
   output logic                result_valid_o,
   output cfp_pkg::coord_type  result_o
);
   import cfp_pkg::*;

   pos_type    pos_ff;
   pos_type    pos_in;
   logic [7:0] xh_ff;
   logic [7:0] xl_ff;
   logic [7:0] yh_ff;
   logic [7:0] yl_ff;
   logic [7:0] ck_ff;
   logic [7:0] sum;

   assign sum = 8'(xh_ff + xl_ff + yh_ff + yl_ff);

   // Next position.
   always_comb begin
      pos_in = pos_ff;
      if (beat_valid_i) begin
         unique case (pos_ff)
            POS_IDLE:  pos_in = (beat_byte_i == HEADER_BYTE) ? POS_HDR2 : POS_IDLE;
            POS_HDR2:  pos_in = (beat_byte_i == HEADER_BYTE) ? POS_XH : POS_IDLE;
            POS_XH:    pos_in = POS_XL;
            POS_XL:    pos_in = POS_YH;
            POS_YH:    pos_in = POS_YL;
            POS_YL:    pos_in = POS_CK;
            POS_CK:    pos_in = POS_TAIL1;
            POS_TAIL1: begin
               if (beat_byte_i == TAIL_BYTE) begin
                  pos_in = POS_TAIL2;
               end else if (beat_byte_i == HEADER_BYTE) begin
                  // A broken tail may itself open the next frame.
                  pos_in = POS_HDR2;
               end else begin
                  pos_in = POS_IDLE;
               end
            end
            POS_TAIL2: pos_in = POS_IDLE;
            default:   pos_in = POS_IDLE;
         endcase
      end
   end

   // Result generation.
   always_comb begin
      result_valid_o   = 1'b0;
      result_o.coord_x = {xh_ff, xl_ff};
      result_o.coord_y = {yh_ff, yl_ff};
      unique case (pos_ff)
         POS_TAIL2: result_valid_o = beat_valid_i && (beat_byte_i == TAIL_BYTE)
                                     && (sum == ck_ff);
         default:   result_valid_o = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= POS_IDLE;
      end else begin
         pos_ff <= pos_in;
      end
   end

   // Payload bytes are captured in place; they need no reset.
   always_ff @(posedge clock) begin
      if (beat_valid_i) begin
         if (pos_ff == POS_XH) xh_ff <= beat_byte_i;
         if (pos_ff == POS_XL) xl_ff <= beat_byte_i;
         if (pos_ff == POS_YH) yh_ff <= beat_byte_i;
         if (pos_ff == POS_YL) yl_ff <= beat_byte_i;
         if (pos_ff == POS_CK) ck_ff <= beat_byte_i;
      end
   end

endmodule

`default_nettype wire

[src/cfp_out_buf.sv]
`default_nettype none

module cfp_out_buf (
   input  logic                clock,
   input  logic                reset,
   input  logic                push_i,
   input  cfp_pkg::coord_type  push_data_i,
   output logic                ready_o,
   output logic                valid_o,
   input  logic                ready_i,
   output cfp_pkg::coord_type  data_o
);
   import cfp_pkg::*;

   logic      head_valid_ff;
   logic      head_valid_in;
   logic      skid_valid_ff;
   logic      skid_valid_in;
   coord_type head_data_ff;
   coord_type head_data_in;
   coord_type skid_data_ff;
   coord_type skid_data_in;
   logic      pop;

   assign pop     = head_valid_ff && ready_i;
   assign ready_o = !skid_valid_ff;
   assign valid_o = head_valid_ff;
   assign data_o  = head_data_ff;

   always_comb begin
      head_valid_in = head_valid_ff;
      head_data_in  = head_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (!head_valid_ff || pop) begin
         if (skid_valid_ff) begin
            head_valid_in = 1'b1;
            head_data_in  = skid_data_ff;
            skid_valid_in = 1'b0;
         end else begin
            head_valid_in = push_i;
            head_data_in  = push_data_i;
         end
      end else if (push_i) begin
         skid_valid_in = 1'b1;
         skid_data_in  = push_data_i;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         head_valid_ff <= head_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      head_data_ff <= head_data_in;
      skid_data_ff <= skid_data_in;
   end

   // The skid slot is only ever filled behind an occupied head.
   assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> head_valid_ff)
      else $error("skid entry held while output register is empty");

   // No result may arrive while both slots are full.
   assert property (@(posedge clock) disable iff (reset)
      !(push_i && skid_valid_ff))
      else $error("result pushed into a full output buffer");

   // A skid entry moves forward when the head is taken.
   assert property (@(posedge clock) disable iff (reset)
      (skid_valid_ff && pop) |=> (head_valid_ff && !skid_valid_ff))
      else $error("skid entry lost on output handoff");

endmodule

`default_nettype wire
